@@ src/spm_pkg.sv @@
// Shared constants, command and status types for the sample playback mixer.
`default_nettype none

package spm_pkg;

  // Channel count and sample store size (store size must be a power of two)
  localparam int NUM_CHANNELS = 4;
  localparam int STORE_BYTES  = 65536;

  localparam int ADDR_W   = $clog2(STORE_BYTES);
  localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Field and channel state widths
  localparam int BASE_W   = 16;
  localparam int LEN_W    = 17;
  localparam int POS_W    = 18;
  localparam int STEP_W   = 20;
  localparam int PHASE_W  = 21;
  localparam int FRAC_W   = 16;
  localparam int ADV_W    = PHASE_W - FRAC_W;
  localparam int GAIN_W   = 8;
  localparam int SMP_W    = 8;
  localparam int SUM_W    = 16;
  localparam int MASK_W   = 4;
  localparam int RD_SUM_W = 21;

  // Item kinds
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_MIX   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic            wr;
    logic            load;
    logic            clr;
    logic            rd;
    logic            mul;
    logic            upd;
    logic            out_ld;
    logic [CH_W-1:0] ch;
  } spm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ch_active;
  } spm_stat_t;

endpackage

`default_nettype wire

@@ src/spm_datapath.sv @@
// Datapath: sample store, channel registers, multiply, phase step and mix sum.
`default_nettype none

module spm_datapath
  import spm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire spm_cmd_t                 cmd,
  output spm_stat_t                     stat,
  input  wire logic [BASE_W-1:0]        addr,
  input  wire logic signed [SMP_W-1:0]  sample_byte,
  input  wire logic [LEN_W-1:0]         length,
  input  wire logic [LEN_W-1:0]         position,
  input  wire logic [STEP_W-1:0]        step,
  input  wire logic [GAIN_W-1:0]        volume,
  output logic signed [SUM_W-1:0]       mix_sample,
  output logic [MASK_W-1:0]             active_mask
);

  // Channel state
  logic [BASE_W-1:0]  chan_base  [NUM_CHANNELS];
  logic [POS_W-1:0]   chan_pos   [NUM_CHANNELS];
  logic [LEN_W-1:0]   chan_len   [NUM_CHANNELS];
  logic [GAIN_W-1:0]  chan_gain  [NUM_CHANNELS];
  logic [STEP_W-1:0]  chan_step  [NUM_CHANNELS];
  logic [PHASE_W-1:0] chan_phase [NUM_CHANNELS];

  // Sample store
  logic [SMP_W-1:0] store [STORE_BYTES];
  logic signed [SMP_W-1:0] rdata;

  // Work registers
  logic [SUM_W-1:0]   prod;
  logic [PHASE_W-1:0] ph_sum;
  logic [SUM_W-1:0]   sum;
  logic [MASK_W-1:0]  mask;

  logic [BASE_W-1:0]   cur_base;
  logic [POS_W-1:0]    cur_pos;
  logic [LEN_W-1:0]    cur_len;
  logic [GAIN_W-1:0]   cur_gain;
  logic [STEP_W-1:0]   cur_step;
  logic [PHASE_W-1:0]  cur_phase;
  logic [RD_SUM_W-1:0] rd_sum;
  logic [PHASE_W-1:0]  ph_m1;
  logic [ADV_W-1:0]    adv;
  logic [PHASE_W-1:0]  ph_new;
  logic [POS_W:0]      pos_adv;
  logic                stop;
  logic [LEN_W-1:0]    len_new;

  // Select the channel in work
  always_comb begin
    cur_base  = chan_base[cmd.ch];
    cur_pos   = chan_pos[cmd.ch];
    cur_len   = chan_len[cmd.ch];
    cur_gain  = chan_gain[cmd.ch];
    cur_step  = chan_step[cmd.ch];
    cur_phase = chan_phase[cmd.ch];
  end

  assign stat.ch_active = (cur_len != '0);
  assign rd_sum = RD_SUM_W'(cur_base) + RD_SUM_W'(cur_pos);

  // Count whole-sample advances: phase steps down while above one sample
  always_comb begin
    ph_m1   = ph_sum - PHASE_W'(1);
    adv     = (ph_sum == '0) ? '0 : ph_m1[PHASE_W-1:FRAC_W];
    ph_new  = ph_sum - {adv, FRAC_W'(0)};
    pos_adv = {1'b0, cur_pos} + (POS_W+1)'(adv);
    stop    = (adv != '0) && (pos_adv >= (POS_W+1)'(cur_len));
    len_new = stop ? '0 : cur_len;
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      store[ADDR_W'(addr)] <= sample_byte;
    end
    if (cmd.rd) begin
      rdata <= store[ADDR_W'(rd_sum)];
    end
  end

  // Channel registers: load and per-mix update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_base[i]  <= '0;
        chan_pos[i]   <= '0;
        chan_len[i]   <= '0;
        chan_gain[i]  <= '0;
        chan_step[i]  <= '0;
        chan_phase[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        chan_base[cmd.ch] <= addr;
        chan_len[cmd.ch]  <= length;
        chan_pos[cmd.ch]  <= {1'b0, position};
        chan_step[cmd.ch] <= step;
        chan_gain[cmd.ch] <= volume;
      end
      if (cmd.upd) begin
        chan_phase[cmd.ch] <= ph_new;
        chan_pos[cmd.ch]   <= pos_adv[POS_W-1:0];
        chan_len[cmd.ch]   <= len_new;
      end
    end
  end

  // Product, phase sum, accumulate and output register
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod   <= SUM_W'(rdata * $signed({1'b0, cur_gain}));
      ph_sum <= cur_phase + PHASE_W'(cur_step);
    end
    if (cmd.clr) begin
      sum  <= '0;
      mask <= '0;
    end
    if (cmd.upd) begin
      sum <= sum + prod;
      for (int i = 0; i < MASK_W; i++) begin
        if (i < NUM_CHANNELS && cmd.ch == CH_W'(i)) begin
          mask[i] <= (len_new != '0);
        end
      end
    end
    if (cmd.out_ld) begin
      mix_sample  <= $signed(sum);
      active_mask <= mask;
    end
  end

endmodule

`default_nettype wire

@@ src/spm_ctrl.sv @@
// Controller: item decode and per-channel mix sequencing.
`default_nettype none

module spm_ctrl
  import spm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] func,
  input  wire logic [1:0] channel,
  output logic            out_valid,
  input  wire logic       out_stall,
  output spm_cmd_t        cmd,
  input  wire spm_stat_t  stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_UPD,
    ST_OUT
  } state_t;

  state_t          state, state_next;
  logic [CH_W-1:0] ch, ch_next;
  logic            out_valid_next;
  logic            last;

  assign last     = (ch == CH_W'(NUM_CHANNELS - 1));
  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    ch_next        = ch;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.ch         = ch;
    case (state)
      ST_IDLE: begin
        cmd.ch = CH_W'(channel);
        if (in_valid) begin
          case (func)
            FUNC_WRITE: cmd.wr = 1'b1;
            FUNC_LOAD:  cmd.load = (32'(channel) < NUM_CHANNELS);
            FUNC_MIX: begin
              cmd.clr    = 1'b1;
              ch_next    = '0;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Skip silent channels, read the sample of a playing one
        if (stat.ch_active) begin
          cmd.rd     = 1'b1;
          state_next = ST_MUL;
        end else if (last) begin
          state_next = ST_OUT;
        end else begin
          ch_next = ch + CH_W'(1);
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        if (last) begin
          state_next = ST_OUT;
        end else begin
          ch_next    = ch + CH_W'(1);
          state_next = ST_SCAN;
        end
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.out_ld     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ch        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ch        <= ch_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ src/sample_playback_mixer.sv @@
// Top level of the four-channel sample playback mixer.
`default_nettype none

// Four-channel wavetable sample mixer. func 0 writes one signed byte into the
// 64 KiB sample store, func 1 loads a channel (base, length, position, step,
// volume; phase is kept), func 2 mixes one output sample and returns it with
// the mask of channels still playing; func 3 is dropped. Byte writes and
// channel loads are taken without stalling the input. A mix holds off
// input while it scans the channels and skips silent ones: the channels
// share one store read port and one multiplier, and each playing channel
// goes through store read, multiply, then accumulate and phase update. A
// finished result sits in an output register, so writes and loads are
// taken while it waits; a following mix stalls only at its end until the
// previous result has been transferred.

module sample_playback_mixer
  import spm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               func,
  input  wire logic [1:0]               channel,
  input  wire logic [BASE_W-1:0]        addr,
  input  wire logic signed [SMP_W-1:0]  sample_byte,
  input  wire logic [LEN_W-1:0]         length,
  input  wire logic [LEN_W-1:0]         position,
  input  wire logic [STEP_W-1:0]        step,
  input  wire logic [GAIN_W-1:0]        volume,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [SUM_W-1:0]       mix_sample,
  output logic [MASK_W-1:0]             active_mask
);

  spm_cmd_t  cmd;
  spm_stat_t stat;

  spm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .channel   (channel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  spm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .addr        (addr),
    .sample_byte (sample_byte),
    .length      (length),
    .position    (position),
    .step        (step),
    .volume      (volume),
    .mix_sample  (mix_sample),
    .active_mask (active_mask)
  );

endmodule

`default_nettype wire

@@ src/spm_checker.sv @@
// Port-level checks for the sample playback mixer, bound to the top level.
`default_nettype none

module spm_checker
  import spm_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic [1:0]               func,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic signed [SUM_W-1:0]  mix_sample,
  input wire logic [MASK_W-1:0]        active_mask
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mix_sample) && $stable(active_mask))
    else $error("stalled result changed");

  // A mix transfer occupies the block on the next cycle
  a_mix_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FUNC_MIX |=> in_stall)
    else $error("mix did not hold off input");

  // Writes, loads and dropped items leave the input free on the next cycle
  a_short_items: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func != FUNC_MIX |=> !in_stall)
    else $error("single-cycle item stalled input");

  // A new result appears only at the end of a mix
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a mix in progress");

endmodule

bind sample_playback_mixer spm_checker u_spm_checker (.*);

`default_nettype wire
